### src/swtq_pkg.sv
// package for the sorted wake-up timer queue
// holds shared constants, codes and the cell control struct; no dependencies

package swtq_pkg;

	localparam int DepthDefault    = 16;
	localparam int TagWidthDefault = 8;
	localparam int WakeWidth       = 64;
	localparam int MsWidth         = 32;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_CANCEL = 2'd1;
	localparam logic [1:0] FUNC_CHECK  = 2'd2;

	typedef enum logic [2:0] {
		KIND_ACCEPTED = 3'd0,
		KIND_FULL     = 3'd1,
		KIND_WOKEN    = 3'd2,
		KIND_DELAY    = 3'd3,
		KIND_EMPTY    = 3'd4,
		KIND_NOTFOUND = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_CANCEL,
		CELL_POP
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_CHECK
	} state_t;

	typedef struct packed {
		cell_op_t               op;
		logic [WakeWidth-1:0]   wake;
	} cell_ctrl_t;

endpackage

### src/sorted_wakeup_timer_queue_core.sv
// sorted wake-up timer queue: insert and cancel give one result on the cycle after the
// request; busy stays low so a new request can follow in the next cycle.
// a time check gives N woken results (N due entries) then one delay or empty result, one per cycle;
// the results follow the state and result registers, and busy is high while the check runs.
// all slots shift in the same cycle through the cell chain; the receiver cannot stall.
// reset clears the state, the slot valid bits, the entry count and the output strobe at once.

module sorted_wakeup_timer_queue_core #(
	parameter int DEPTH     = swtq_pkg::DepthDefault,
	parameter int TAG_WIDTH = swtq_pkg::TagWidthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    func,
	input  logic [TAG_WIDTH-1:0]          client_tag,
	input  logic [swtq_pkg::MsWidth-1:0]  revive_months,
	input  logic [swtq_pkg::MsWidth-1:0]  revive_ms,
	input  logic [swtq_pkg::MsWidth-1:0]  clock_ms,
	input  logic [swtq_pkg::MsWidth-1:0]  last_ms,
	input  logic [swtq_pkg::MsWidth-1:0]  last_months,
	output logic                          strobe,
	output logic [2:0]                    kind,
	output logic [TAG_WIDTH-1:0]          result_tag,
	output logic [swtq_pkg::MsWidth-1:0]  delay_ms,
	output logic                          last
);

	localparam int CntW = $clog2(DEPTH + 1);
	localparam int WW   = swtq_pkg::WakeWidth;
	localparam int MW   = swtq_pkg::MsWidth;

	swtq_pkg::state_t     state_q, state_d;
	swtq_pkg::cell_ctrl_t ctrl;
	logic [CntW-1:0]      count_q, count_d;
	logic [WW-1:0]        now_q;
	logic [MW-1:0]        diff;
	logic [MW-1:0]        now_months;

	logic                 strobe_q, strobe_d;
	swtq_pkg::kind_t      kind_q, kind_d;
	logic [TAG_WIDTH-1:0] tag_q, tag_d;
	logic [MW-1:0]        delay_q, delay_d;
	logic                 last_q, last_d;

	logic [DEPTH-1:0]     valid_c, keep_c, hit_c;
	logic [TAG_WIDTH-1:0] tag_c  [DEPTH];
	logic [WW-1:0]        wake_c [DEPTH];

	logic                 accept;
	logic                 full;
	logic                 head_due;

	assign accept   = start && !busy;
	assign full     = (count_q == CntW'(DEPTH));
	assign busy     = (state_q == swtq_pkg::ST_CHECK);
	assign head_due = valid_c[0] && (wake_c[0] <= now_q);

	// month rolls over when the ms clock has wrapped past the last recorded time
	assign diff       = clock_ms - last_ms;
	assign now_months = last_months + {{(MW-1){1'b0}}, diff[MW-1]};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                 p_valid, p_keep, p_hit, n_valid;
		logic [TAG_WIDTH-1:0] p_tag, n_tag;
		logic [WW-1:0]        p_wake, n_wake;

		if (i == 0) begin : g_head
			assign p_valid = 1'b1;
			assign p_keep  = 1'b1;
			assign p_hit   = 1'b0;
			assign p_tag   = '0;
			assign p_wake  = '0;
		end else begin : g_body
			assign p_valid = valid_c[i-1];
			assign p_keep  = keep_c[i-1];
			assign p_hit   = hit_c[i-1];
			assign p_tag   = tag_c[i-1];
			assign p_wake  = wake_c[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_tag   = '0;
			assign n_wake  = '0;
		end else begin : g_inner
			assign n_valid = valid_c[i+1];
			assign n_tag   = tag_c[i+1];
			assign n_wake  = wake_c[i+1];
		end

		swtq_cell #(
			.TAG_WIDTH(TAG_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_tag    (client_tag),
			.prev_valid (p_valid),
			.prev_keep  (p_keep),
			.prev_hit   (p_hit),
			.prev_tag   (p_tag),
			.prev_wake  (p_wake),
			.next_valid (n_valid),
			.next_tag   (n_tag),
			.next_wake  (n_wake),
			.valid      (valid_c[i]),
			.tag        (tag_c[i]),
			.wake       (wake_c[i]),
			.keep       (keep_c[i]),
			.hit        (hit_c[i])
		);
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ctrl.op   = swtq_pkg::CELL_HOLD;
		ctrl.wake = {revive_months, revive_ms};
		strobe_d  = 1'b0;
		kind_d    = swtq_pkg::KIND_ACCEPTED;
		tag_d     = client_tag;
		delay_d   = '0;
		last_d    = 1'b1;
		case (state_q)
			swtq_pkg::ST_IDLE: begin
				if (accept) begin
					if (func == swtq_pkg::FUNC_INSERT) begin
						strobe_d = 1'b1;
						if (full) begin
							kind_d = swtq_pkg::KIND_FULL;
						end else begin
							ctrl.op = swtq_pkg::CELL_INSERT;
							count_d = count_q + CntW'(1);
						end
					end else if (func == swtq_pkg::FUNC_CANCEL) begin
						strobe_d = 1'b1;
						ctrl.op  = swtq_pkg::CELL_CANCEL;
						if (hit_c[DEPTH-1]) begin
							kind_d  = swtq_pkg::KIND_WOKEN;
							count_d = count_q - CntW'(1);
						end else begin
							kind_d = swtq_pkg::KIND_NOTFOUND;
						end
					end else if (func == swtq_pkg::FUNC_CHECK) begin
						state_d = swtq_pkg::ST_CHECK;
					end
				end
			end
			swtq_pkg::ST_CHECK: begin
				strobe_d = 1'b1;
				if (head_due) begin
					ctrl.op = swtq_pkg::CELL_POP;
					count_d = count_q - CntW'(1);
					kind_d  = swtq_pkg::KIND_WOKEN;
					tag_d   = tag_c[0];
					last_d  = 1'b0;
				end else begin
					state_d = swtq_pkg::ST_IDLE;
					tag_d   = '0;
					if (valid_c[0]) begin
						kind_d  = swtq_pkg::KIND_DELAY;
						delay_d = wake_c[0][MW-1:0] - now_q[MW-1:0];
					end else begin
						kind_d = swtq_pkg::KIND_EMPTY;
					end
				end
			end
			default: begin
				state_d = swtq_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= swtq_pkg::ST_IDLE;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q  <= kind_d;
		tag_q   <= tag_d;
		delay_q <= delay_d;
		last_q  <= last_d;
		if (accept && func == swtq_pkg::FUNC_CHECK) begin
			now_q <= {now_months, clock_ms};
		end
	end

	assign strobe     = strobe_q;
	assign kind       = kind_q;
	assign result_tag = tag_q;
	assign delay_ms   = delay_q;
	assign last       = last_q;

	// entry count always equals the number of occupied slots
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		CntW'($countones(valid_c)) == count_q)
		else $error("entry count does not match occupied slots");

	// occupied slots form a prefix of the chain
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_c + DEPTH'(1)) & valid_c) == '0)
		else $error("gap in occupied slots");

	// a non-final result only comes out while a time check is still running
	a_nonlast_in_check: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_q |-> state_q == swtq_pkg::ST_CHECK)
		else $error("non-final result outside a time check");

	// an accepted time check always raises busy, followed by a result strobe
	a_check_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == swtq_pkg::FUNC_CHECK |=> busy ##1 strobe_q)
		else $error("time check did not start");

endmodule

### src/swtq_cell.sv
// one slot of the sorted queue: valid, tag and wake time
// shifts toward or away from its neighbors under command; uses swtq_pkg

module swtq_cell #(
	parameter int TAG_WIDTH = swtq_pkg::TagWidthDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  swtq_pkg::cell_ctrl_t             ctrl,
	input  logic [TAG_WIDTH-1:0]             new_tag,
	input  logic                             prev_valid,
	input  logic                             prev_keep,
	input  logic                             prev_hit,
	input  logic [TAG_WIDTH-1:0]             prev_tag,
	input  logic [swtq_pkg::WakeWidth-1:0]   prev_wake,
	input  logic                             next_valid,
	input  logic [TAG_WIDTH-1:0]             next_tag,
	input  logic [swtq_pkg::WakeWidth-1:0]   next_wake,
	output logic                             valid,
	output logic [TAG_WIDTH-1:0]             tag,
	output logic [swtq_pkg::WakeWidth-1:0]   wake,
	output logic                             keep,
	output logic                             hit
);

	logic                             valid_q;
	logic [TAG_WIDTH-1:0]             tag_q;
	logic [swtq_pkg::WakeWidth-1:0]   wake_q;
	logic                             match;
	logic                             at_or_after;

	assign keep        = valid_q && (wake_q <= ctrl.wake);
	assign match       = valid_q && (tag_q == new_tag);
	assign hit         = prev_hit || match;
	assign at_or_after = hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				swtq_pkg::CELL_INSERT: begin
					valid_q <= valid_q || prev_valid;
				end
				swtq_pkg::CELL_CANCEL: begin
					if (at_or_after) begin
						valid_q <= next_valid;
					end
				end
				swtq_pkg::CELL_POP: begin
					valid_q <= next_valid;
				end
				default: begin
					valid_q <= valid_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			swtq_pkg::CELL_INSERT: begin
				// entries past the insertion point move one slot back
				if (!keep) begin
					if (prev_keep) begin
						tag_q  <= new_tag;
						wake_q <= ctrl.wake;
					end else begin
						tag_q  <= prev_tag;
						wake_q <= prev_wake;
					end
				end
			end
			swtq_pkg::CELL_CANCEL: begin
				if (at_or_after) begin
					tag_q  <= next_tag;
					wake_q <= next_wake;
				end
			end
			swtq_pkg::CELL_POP: begin
				tag_q  <= next_tag;
				wake_q <= next_wake;
			end
			default: begin
				tag_q  <= tag_q;
				wake_q <= wake_q;
			end
		endcase
	end

	assign valid = valid_q;
	assign tag   = tag_q;
	assign wake  = wake_q;

endmodule

### tb/sv/testbench.sv
// self-checking testbench for sorted_wakeup_timer_queue_core
// drives insert, cancel and time check requests and checks every result against a queue model
// depends on swtq_pkg and the core

module testbench;

	localparam int QueueDepth = swtq_pkg::DepthDefault;
	localparam int CycleLimit = 100000;
	localparam int DrainCycles = 40;
	localparam int RandomRequests = 160;
	localparam logic [1:0] FuncUnused = 2'd3;

	typedef struct {
		logic [7:0]  tag;
		logic [63:0] wake;
	} sleeper_t;

	typedef struct {
		swtq_pkg::kind_t kind;
		logic [7:0]      tag;
		logic [31:0]     delay;
		logic            last;
	} wake_result_t;

	class wakeup_scoreboard;
		sleeper_t     sleepers[$];
		wake_result_t pending[$];
		int           errors = 0;

		function void push_result(swtq_pkg::kind_t k, logic [7:0] t, logic [31:0] d, logic l);
			wake_result_t r;
			r.kind = k;
			r.tag = t;
			r.delay = d;
			r.last = l;
			pending.push_back(r);
		endfunction

		// update the sleeper list for one accepted request and queue its results
		function void note_request(logic [1:0] f, logic [7:0] t, logic [31:0] rmo,
				logic [31:0] rms, logic [31:0] cms, logic [31:0] lms, logic [31:0] lmo);
			sleeper_t    s;
			int          pos;
			logic [31:0] months;
			logic [31:0] diff;
			logic [63:0] now;
			bit          found;
			case (f)
				swtq_pkg::FUNC_INSERT: begin
					if (sleepers.size() >= QueueDepth) begin
						push_result(swtq_pkg::KIND_FULL, t, '0, 1'b1);
					end else begin
						s.tag = t;
						s.wake = {rmo, rms};
						pos = 0;
						// equal wake times keep arrival order
						while (pos < sleepers.size() && sleepers[pos].wake <= s.wake)
							pos++;
						sleepers.insert(pos, s);
						push_result(swtq_pkg::KIND_ACCEPTED, t, '0, 1'b1);
					end
				end
				swtq_pkg::FUNC_CANCEL: begin
					found = 0;
					for (pos = 0; pos < sleepers.size() && !found; pos++) begin
						if (sleepers[pos].tag == t) begin
							sleepers.delete(pos);
							found = 1;
						end
					end
					if (found)
						push_result(swtq_pkg::KIND_WOKEN, t, '0, 1'b1);
					else
						push_result(swtq_pkg::KIND_NOTFOUND, t, '0, 1'b1);
				end
				swtq_pkg::FUNC_CHECK: begin
					diff = cms - lms;
					// a negative signed difference means the ms clock wrapped
					months = lmo + {31'd0, diff[31]};
					now = {months, cms};
					while (sleepers.size() > 0 && sleepers[0].wake <= now) begin
						push_result(swtq_pkg::KIND_WOKEN, sleepers[0].tag, '0, 1'b0);
						sleepers.pop_front();
					end
					if (sleepers.size() > 0)
						push_result(swtq_pkg::KIND_DELAY, '0, sleepers[0].wake[31:0] - cms,
							1'b1);
					else
						push_result(swtq_pkg::KIND_EMPTY, '0, '0, 1'b1);
				end
				default: begin
				end
			endcase
		endfunction

		function void check_result(logic [2:0] k, logic [7:0] t, logic [31:0] d, logic l);
			wake_result_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: kind %0d tag %0d", k, t);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (k !== e.kind) begin
				$error("kind expected %0d actual %0d", e.kind, k);
				errors++;
			end
			if (t !== e.tag) begin
				$error("result_tag expected %0d actual %0d", e.tag, t);
				errors++;
			end
			if (d !== e.delay) begin
				$error("delay_ms expected %0h actual %0h", e.delay, d);
				errors++;
			end
			if (l !== e.last) begin
				$error("last expected %0d actual %0d", e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  func = '0;
	logic [7:0]  client_tag = '0;
	logic [31:0] revive_months = '0;
	logic [31:0] revive_ms = '0;
	logic [31:0] clock_ms = '0;
	logic [31:0] last_ms = '0;
	logic [31:0] last_months = '0;
	logic        strobe;
	logic [2:0]  kind;
	logic [7:0]  result_tag;
	logic [31:0] delay_ms;
	logic        last;

	wakeup_scoreboard sb = new();
	int cycles = 0;

	sorted_wakeup_timer_queue_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.client_tag   (client_tag),
		.revive_months(revive_months),
		.revive_ms    (revive_ms),
		.clock_ms     (clock_ms),
		.last_ms      (last_ms),
		.last_months  (last_months),
		.strobe       (strobe),
		.kind         (kind),
		.result_tag   (result_tag),
		.delay_ms     (delay_ms),
		.last         (last)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// results first so a strobe never matches a request taken at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe === 1'b1)
				sb.check_result(kind, result_tag, delay_ms, last);
			if (start && busy === 1'b0)
				sb.note_request(func, client_tag, revive_months, revive_ms, clock_ms,
					last_ms, last_months);
		end
	end

	task automatic send_request(input logic [1:0] f, input logic [7:0] t,
			input logic [31:0] rmo, input logic [31:0] rms, input logic [31:0] cms,
			input logic [31:0] lms, input logic [31:0] lmo);
		int roll;
		int pause;
		start <= 1'b1;
		func <= f;
		client_tag <= t;
		revive_months <= rmo;
		revive_ms <= rms;
		clock_ms <= cms;
		last_ms <= lms;
		last_months <= lmo;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		roll = $urandom_range(0, 99);
		if (roll < 40)
			pause = 0;
		else if (roll < 85)
			pause = $urandom_range(1, 3);
		else
			pause = $urandom_range(5, 30);
		if (pause > 0) begin
			start <= 1'b0;
			repeat (pause) begin
				func <= 2'($urandom);
				client_tag <= 8'($urandom);
				revive_months <= $urandom;
				revive_ms <= $urandom;
				clock_ms <= $urandom;
				last_ms <= $urandom;
				last_months <= $urandom;
				@(posedge clk);
			end
		end
	endtask

	task automatic time_check(input logic [31:0] cms, input logic [31:0] lms,
			input logic [31:0] lmo);
		send_request(swtq_pkg::FUNC_CHECK, 8'($urandom), $urandom, $urandom, cms, lms, lmo);
	endtask

	initial begin
		logic [31:0] base_mo;
		logic [31:0] base_ms;
		logic [31:0] cms;
		logic [31:0] diff;
		logic [63:0] wake;
		logic [7:0]  tag;
		int          roll;
		int          pick;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, absent tag, unused code
		time_check(32'd100, 32'd50, 32'd0);
		send_request(swtq_pkg::FUNC_CANCEL, 8'hFF, '0, '0, '0, '0, '0);
		send_request(FuncUnused, 8'h55, '1, '1, '1, '1, '1);
		// fill the queue: pairs of equal wake times, repeated tags, both extremes
		for (int i = 0; i < QueueDepth; i++) begin
			if (i == QueueDepth - 1)
				send_request(swtq_pkg::FUNC_INSERT, 8'hFF, '1, '1, '0, '0, '0);
			else
				send_request(swtq_pkg::FUNC_INSERT, 8'(i % 6), 32'(i >> 2),
					32'd500 * 32'((i >> 1) & 1), '1, '1, '1);
		end
		send_request(swtq_pkg::FUNC_INSERT, 8'hAA, 32'd0, 32'd0, '0, '0, '0);
		send_request(swtq_pkg::FUNC_CANCEL, 8'd2, '0, '0, '0, '0, '0);
		send_request(swtq_pkg::FUNC_CANCEL, 8'h77, '0, '0, '0, '0, '0);
		// wrapped ms clock bumps the month
		time_check(32'h0000_0010, 32'h7000_0000, 32'd1);
		time_check(32'h7FFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		time_check(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// month count wraps to zero
		time_check(32'h0000_0000, 32'h0000_0010, 32'hFFFF_FFFF);

		// random: wake times stay near a moving current time so checks wake entries
		base_mo = $urandom_range(0, 3);
		base_ms = 32'hFFFF_0000 + $urandom_range(0, 4095);
		for (int n = 0; n < RandomRequests; n++) begin
			roll = $urandom_range(0, 99);
			tag = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 7));
			if (roll < 45) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					wake = {base_mo, base_ms} + 64'($urandom_range(0, 4000));
				else if (pick < 80)
					wake = {base_mo, base_ms} + 64'(1000 * $urandom_range(0, 1));
				else if (pick < 90)
					wake = {base_mo, base_ms} - 64'($urandom_range(0, 1000));
				else
					wake = {$urandom, $urandom};
				send_request(swtq_pkg::FUNC_INSERT, tag, wake[63:32], wake[31:0], $urandom,
					$urandom, $urandom);
			end else if (roll < 63) begin
				send_request(swtq_pkg::FUNC_CANCEL, tag, $urandom, $urandom, $urandom,
					$urandom, $urandom);
			end else if (roll < 96) begin
				pick = $urandom_range(0, 99);
				if (pick < 75)
					cms = base_ms + $urandom_range(0, 2500);
				else if (pick < 88)
					cms = $urandom;
				else
					cms = base_ms;
				time_check(cms, base_ms, base_mo);
				diff = cms - base_ms;
				base_mo = base_mo + {31'd0, diff[31]};
				base_ms = cms;
			end else begin
				send_request(FuncUnused, tag, $urandom, $urandom, $urandom, $urandom, $urandom);
			end
		end

		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
src/swtq_pkg.sv
src/swtq_cell.sv
src/sorted_wakeup_timer_queue_core.sv
tb/sv/testbench.sv
